/* rtl/srr_pkg.sv */
// Package for the selective-repeat receiver.
// Holds the controller state type, register and result codes, and the byte-sum helper.
// No dependencies.
package srr_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_ACK,
        ST_RD,
        ST_LOAD,
        ST_DLV
    } state_t;

    // Result kinds carried on tuser
    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_DLV = 1'b1;

    // Register word index (paddr[2])
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic [4:0] WIN_RESET = 5'd8;

    // Payload: 20 bytes
    localparam int PAYLOAD_W = 160;

    // Shared adder steps: five payload words, then the sequence number
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;
    localparam logic [STEP_W-1:0] STEP_SEQ = 3'd5;

    // Sum of four bytes of a word, each taken as signed
    function automatic logic [31:0] byte_sum4(input logic [31:0] w);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < 4; i++)
        begin
            s = s + {{24{w[8*i+7]}}, w[8*i +: 8]};
        end
        return s;
    endfunction

endpackage

/* rtl/srr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srr_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/srr_sum_unit.sv */
// Shared accumulator for the packet checksum: one 32-bit word of signed bytes per step,
// then the sequence number. Depends on srr_pkg.
module srr_sum_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [159:0] payload,
    input  logic [31:0]  seq_word,
    output logic         done,
    output logic [31:0]  sum
);
    import srr_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         operand;

    // Operand select for the current step
    always_comb
    begin
        case (step_reg)
            3'd0:    operand = byte_sum4(payload[31:0]);
            3'd1:    operand = byte_sum4(payload[63:32]);
            3'd2:    operand = byte_sum4(payload[95:64]);
            3'd3:    operand = byte_sum4(payload[127:96]);
            3'd4:    operand = byte_sum4(payload[159:128]);
            STEP_SEQ: operand = seq_word;
            default: operand = '0;
        endcase
    end

    assign done = busy_reg && (step_reg == STEP_LAST);

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + operand;
            step_next = step_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign sum = acc_reg;

endmodule

/* rtl/selective_repeat_receiver_core.sv */
// Selective-repeat ARQ receiver core. The ack item is registered once the packet is accepted, the
// shared checksum adder has run its 6 steps and the check state has passed. A dropped item returns
// to idle straight from the check, an acked one after its ack handshake. A delivery run goes through
// load and handshake for its first item, then slot RAM read, load and handshake for each further one.
// Reset: window size 8, expected sequence 1, ring head 0, all slot marks cleared; the slot
// payload RAM is not cleared, so reset takes effect at once with no clearing pass.
module selective_repeat_receiver_core #(
    parameter int WINDOW_MAX = 16,
    parameter int SEQ_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // Input packets
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: seq_num[15:0], ack_num[31:16], check_sum[63:32], payload_lo[127:64],
    //          payload_mid[191:128], payload_hi[223:192]
    input  logic [223:0] s_tdata,
    // Results
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: out_seq[15:0], out_checksum[47:16], out_payload_lo[111:48],
    //          out_payload_mid[175:112], out_payload_hi[207:176]
    output logic [207:0] m_tdata,
    output logic         m_tlast,
    // m_tuser: kind[0]
    output logic         m_tuser,
    // Configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import srr_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_MAX);

    state_t                 state_reg, state_next;
    logic [4:0]             win_reg, win_next;
    logic [SEQ_BITS-1:0]    expected_reg, expected_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [WINDOW_MAX-1:0]  valid_reg, valid_next;
    logic                   deliver_reg, deliver_next;

    // Captured packet
    logic [15:0]            seq_reg;
    logic [15:0]            ack_reg;
    logic [31:0]            cs_reg;
    logic [PAYLOAD_W-1:0]   pl_reg;

    // Output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   out_kind_reg, out_kind_next;
    logic                   out_last_reg, out_last_next;
    logic [15:0]            out_seq_reg, out_seq_next;
    logic [31:0]            out_cs_reg, out_cs_next;
    logic [PAYLOAD_W-1:0]   out_pl_reg, out_pl_next;

    logic                   in_take;
    logic                   sum_done;
    logic [31:0]            sum;
    logic [SEQ_BITS-1:0]    seq_m;
    logic [SEQ_BITS-1:0]    offset;
    logic [4:0]             win_eff;
    logic                   in_win;
    logic                   cs_ok;
    logic [IDX_W:0]         slot_sum;
    logic [IDX_W-1:0]       slot;
    logic [IDX_W-1:0]       head_inc;
    logic                   ram_we;
    logic [PAYLOAD_W-1:0]   ram_rdata;
    logic                   cfg_wr;

    assign in_take = s_tvalid && s_tready;

    // Shared checksum adder
    srr_sum_unit u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_take),
        .payload  (pl_reg),
        .seq_word (32'(seq_m)),
        .done     (sum_done),
        .sum      (sum)
    );

    // Slot payload store
    srr_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (WINDOW_MAX)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (pl_reg),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Window math
    assign seq_m  = SEQ_BITS'(seq_reg);
    assign offset = seq_m - expected_reg;
    assign cs_ok  = ((sum + {16'd0, ack_reg}) == cs_reg);

    always_comb
    begin
        win_eff = win_reg;
        if (win_reg == 5'd0)
        begin
            win_eff = 5'd1;
        end
        else if ({27'd0, win_reg} > 32'(WINDOW_MAX))
        begin
            win_eff = 5'(WINDOW_MAX);
        end
    end

    assign in_win   = (offset < SEQ_BITS'(win_eff));
    assign slot_sum = {1'b0, head_reg} + (IDX_W+1)'(offset);
    assign slot     = (slot_sum >= (IDX_W+1)'(WINDOW_MAX))
                    ? IDX_W'(slot_sum - (IDX_W+1)'(WINDOW_MAX)) : IDX_W'(slot_sum);
    assign head_inc = (head_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : head_reg + 1'b1;

    assign ram_we = (state_reg == ST_CHECK) && cs_ok && in_win;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        expected_next = expected_reg;
        head_next     = head_reg;
        valid_next    = valid_reg;
        deliver_next  = deliver_reg;
        m_tvalid_next = m_tvalid_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        out_seq_next  = out_seq_reg;
        out_cs_next   = out_cs_reg;
        out_pl_next   = out_pl_reg;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (sum_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!cs_ok)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    m_tvalid_next = 1'b1;
                    out_kind_next = KIND_ACK;
                    out_seq_next  = 16'(seq_m);
                    out_cs_next   = sum;
                    out_pl_next   = pl_reg;
                    out_last_next = !(in_win && (offset == '0));
                    deliver_next  = in_win && (offset == '0);
                    if (in_win)
                    begin
                        valid_next[slot] = 1'b1;
                    end
                    state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    state_next    = deliver_reg ? ST_LOAD : ST_IDLE;
                end
            end
            ST_RD:
            begin
                // RAM address follows the new head; data lands next cycle
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                m_tvalid_next = 1'b1;
                out_kind_next = KIND_DLV;
                out_seq_next  = 16'(expected_reg);
                out_cs_next   = '0;
                out_pl_next   = ram_rdata;
                out_last_next = !valid_reg[head_inc];
                state_next    = ST_DLV;
            end
            ST_DLV:
            begin
                if (m_tready)
                begin
                    m_tvalid_next        = 1'b0;
                    valid_next[head_reg] = 1'b0;
                    head_next            = head_inc;
                    expected_next        = expected_reg + 1'b1;
                    state_next           = out_last_reg ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? {27'd0, win_reg} : '0;

    always_comb
    begin
        win_next = win_reg;
        if (cfg_wr && (paddr[2] == REG_WINDOW_SIZE))
        begin
            win_next = pwdata[4:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            win_reg      <= WIN_RESET;
            expected_reg <= SEQ_BITS'(1);
            head_reg     <= '0;
            valid_reg    <= '0;
            deliver_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            win_reg      <= win_next;
            expected_reg <= expected_next;
            head_reg     <= head_next;
            valid_reg    <= valid_next;
            deliver_reg  <= deliver_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            seq_reg <= s_tdata[15:0];
            ack_reg <= s_tdata[31:16];
            cs_reg  <= s_tdata[63:32];
            pl_reg  <= s_tdata[223:64];
        end
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_seq_reg  <= out_seq_next;
        out_cs_reg   <= out_cs_next;
        out_pl_reg   <= out_pl_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_pl_reg, out_cs_reg, out_seq_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

`ifndef SYNTH
    // No new packet is taken while a result is pending
    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    // A delivery always comes from a marked head slot
    a_dlv_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_DLV)) |-> valid_reg[head_reg])
        else $error("delivery from an unmarked slot");

    // Each taken delivery advances the expected sequence by one
    a_dlv_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && (m_tuser == KIND_DLV))
        |=> (expected_reg == $past(expected_reg) + 1'b1))
        else $error("expected sequence did not advance");
`endif

endmodule

/* sim/tb_selective_repeat_receiver_core.sv */
// Testbench for the selective-repeat receiver core: packets in, acks and in-order deliveries out.
// A self-checking tracker predicts every result; depends on srr_pkg and the core RTL only.
module tb_selective_repeat_receiver_core;
    import srr_pkg::*;

    localparam int RING_DEPTH = 16;
    localparam int DRAIN_GAP = 24;
    localparam int TAIL_CYCLES = 80;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES = 7;
    localparam logic [2:0] WINDOW_ADDR = {REG_WINDOW_SIZE, 2'b00};

    // Per phase: window setting, sender idle %, receiver stall %, item count, hold-off
    localparam int PHASE_WIN[NUM_PHASES] = '{16, 4, 0, 31, 1, 16, 12};
    localparam int PHASE_SEND_IDLE[NUM_PHASES] = '{0, 51, 0, 6, 51, 0, 6};
    localparam int PHASE_RECV_STALL[NUM_PHASES] = '{0, 0, 51, 6, 0, 0, 6};
    localparam int PHASE_ITEMS[NUM_PHASES] = '{40, 40, 30, 40, 20, 45, 35};
    localparam int PHASE_HOLD[NUM_PHASES] = '{0, 0, 0, 0, 0, HOLD_CYCLES, 0};

    typedef struct {
        logic [15:0] seq;
        logic [15:0] ack;
        logic [31:0] csum;
        logic [63:0] lo;
        logic [63:0] mid;
        logic [31:0] hi;
    } packet_t;

    typedef struct {
        logic        kind;
        logic [15:0] seq;
        logic [31:0] csum;
        logic [63:0] lo;
        logic [63:0] mid;
        logic [31:0] hi;
        logic        last;
    } result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [207:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;

    // Sum of the 20 payload bytes, each taken as signed
    function automatic logic [31:0] signed_byte_total(input logic [159:0] bytes);
        logic [31:0] total;
        total = '0;
        for (int i = 0; i < 20; i++)
        begin
            total = total + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
        end
        return total;
    endfunction

    // Tracks the receive window and holds the results still owed by the core
    class arq_receive_tracker;
        logic [4:0]  window_reg;
        logic [15:0] base_seq;
        int unsigned ring_head;
        bit          marked[RING_DEPTH];
        logic [63:0] held_lo[RING_DEPTH];
        logic [63:0] held_mid[RING_DEPTH];
        logic [31:0] held_hi[RING_DEPTH];
        result_t     owed[$];
        int          failures;

        function new();
            window_reg = WIN_RESET;
            base_seq = 16'd1;
            ring_head = 0;
            failures = 0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                marked[i] = 1'b0;
            end
        endfunction

        // Effective window: zero acts as one, large values saturate
        function int unsigned span();
            if (window_reg == 0)
                return 1;
            if (window_reg > RING_DEPTH)
                return RING_DEPTH;
            return window_reg;
        endfunction

        function void set_window(input logic [4:0] value);
            window_reg = value;
        endfunction

        function void packet_accepted(input packet_t p);
            logic [31:0] psum;
            logic [31:0] total;
            logic [15:0] offset;
            int unsigned slot;
            int          d;
            result_t     r;
            psum = signed_byte_total({p.hi, p.mid, p.lo});
            total = {16'h0, p.seq} + {16'h0, p.ack} + psum;
            // Corrupted packet: silently dropped
            if (total != p.csum)
                return;
            offset = p.seq - base_seq;
            r.kind = KIND_ACK;
            r.seq = p.seq;
            r.csum = {16'h0, p.seq} + psum;
            r.lo = p.lo;
            r.mid = p.mid;
            r.hi = p.hi;
            r.last = !(offset == 0);
            owed.insert(owed.size(), r);
            if (offset < span())
            begin
                slot = (ring_head + offset) % RING_DEPTH;
                marked[slot] = 1'b1;
                held_lo[slot] = p.lo;
                held_mid[slot] = p.mid;
                held_hi[slot] = p.hi;
                // Base arrived: deliver the unbroken run of marked slots
                d = 0;
                while (offset == 0 && d < RING_DEPTH && marked[ring_head])
                begin
                    r.kind = KIND_DLV;
                    r.seq = base_seq;
                    r.csum = '0;
                    r.lo = held_lo[ring_head];
                    r.mid = held_mid[ring_head];
                    r.hi = held_hi[ring_head];
                    marked[ring_head] = 1'b0;
                    ring_head = (ring_head + 1) % RING_DEPTH;
                    base_seq = base_seq + 16'd1;
                    d++;
                    r.last = (d == RING_DEPTH) || !marked[ring_head];
                    owed.insert(owed.size(), r);
                end
            end
        endfunction

        function void compare_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void result_seen(input result_t r);
            result_t want;
            if (owed.size() == 0)
            begin
                $error("unexpected result item: kind %0d seq %0h", r.kind, r.seq);
                failures++;
                return;
            end
            want = owed.pop_front();
            compare_field("kind", want.kind, r.kind);
            compare_field("out_seq", want.seq, r.seq);
            compare_field("out_checksum", want.csum, r.csum);
            compare_field("out_payload_lo", want.lo, r.lo);
            compare_field("out_payload_mid", want.mid, r.mid);
            compare_field("out_payload_hi", want.hi, r.hi);
            compare_field("last", want.last, r.last);
        endfunction
    endclass

    arq_receive_tracker tracker;
    packet_t            directed_items[$];
    // Planned sequence numbers; bit 16 marks an item to corrupt
    logic [16:0]        seq_plan[$];

    selective_repeat_receiver_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Builds a packet with a correct checksum, or a broken one on request
    function automatic packet_t make_packet(input logic [15:0] seq, input logic [15:0] ack,
                                            input logic [63:0] lo, input logic [63:0] mid,
                                            input logic [31:0] hi, input bit corrupt);
        packet_t     p;
        logic [31:0] junk;
        p.seq = seq;
        p.ack = ack;
        p.lo = lo;
        p.mid = mid;
        p.hi = hi;
        p.csum = {16'h0, seq} + {16'h0, ack} + signed_byte_total({hi, mid, lo});
        if (corrupt)
        begin
            junk = $urandom;
            if (junk == 0)
                junk = 32'h1;
            p.csum = p.csum ^ junk;
        end
        return p;
    endfunction

    // Plans either a whole window from the base in scrambled order, or one noise item
    function automatic void plan_more();
        logic [16:0] order[$];
        logic [16:0] swap;
        int unsigned win;
        int unsigned j;
        win = tracker.span();
        if ($urandom_range(99) < 70)
        begin
            if ($urandom_range(3) == 0)
            begin
                // Reversed: base comes last, so the whole window is delivered at once
                for (int i = win - 1; i >= 0; i--)
                begin
                    order.insert(order.size(), {1'b0, tracker.base_seq + 16'(i)});
                end
            end
            else
            begin
                for (int i = 0; i < win; i++)
                begin
                    order.insert(order.size(), {1'b0, tracker.base_seq + 16'(i)});
                end
                for (int i = win - 1; i > 0; i--)
                begin
                    j = $urandom_range(i);
                    swap = order[i];
                    order[i] = order[j];
                    order[j] = swap;
                end
            end
            foreach (order[i])
            begin
                order[i][16] = ($urandom_range(99) < 5);
                seq_plan.insert(seq_plan.size(), order[i]);
            end
        end
        else
        begin
            case ($urandom_range(3))
                0: seq_plan.insert(seq_plan.size(),
                                   {1'b0, tracker.base_seq - 16'($urandom_range(1, 40))});
                1: seq_plan.insert(seq_plan.size(), {1'b0, tracker.base_seq + 16'(win)
                                   + 16'($urandom_range(0, 20))});
                2: seq_plan.insert(seq_plan.size(), {1'b0, 16'($urandom)});
                default: seq_plan.insert(seq_plan.size(), {1'b1, 16'($urandom)});
            endcase
        end
    endfunction

    function automatic packet_t fetch_packet();
        logic [16:0] entry;
        if (seq_plan.size() == 0)
            plan_more();
        entry = seq_plan.pop_front();
        return make_packet(entry[15:0], 16'($urandom), rand64(), rand64(), $urandom,
                           entry[16]);
    endfunction

    // Offers packets until the given number has been accepted
    task automatic send_packets(input int count);
        packet_t pkt;
        int      offered;
        int      taken;
        bit      waiting;
        offered = 0;
        taken = 0;
        waiting = 1'b0;
        while (taken < count)
        begin
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                tracker.packet_accepted(pkt);
                taken++;
                waiting = 1'b0;
            end
            if (!waiting && offered < count && $urandom_range(99) >= send_idle_pct)
            begin
                if (directed_items.size() != 0)
                    pkt = directed_items.pop_front();
                else
                    pkt = fetch_packet();
                s_tdata <= {pkt.hi, pkt.mid, pkt.lo, pkt.csum, pkt.ack, pkt.seq};
                s_tvalid <= 1'b1;
                waiting = 1'b1;
                offered++;
            end
            else if (!waiting)
            begin
                s_tvalid <= 1'b0;
            end
        end
    endtask

    // Waits for every owed result, then lets a dropped packet finish inside the core
    task automatic wait_for_drain();
        while (tracker.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // Register write followed by a read-back
    task automatic write_window(input logic [4:0] value);
        logic [31:0] readback;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= WINDOW_ADDR;
        pwdata <= {27'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_window(value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== {27'h0, value})
        begin
            $error("window_size mismatch: expected %0h, got %0h", value, readback);
            tracker.failures++;
        end
    endtask

    // Result side: random backpressure plus an occasional long hold-off
    initial
    begin : result_sink
        result_t got;
        int      hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.seq = m_tdata[15:0];
                got.csum = m_tdata[47:16];
                got.lo = m_tdata[111:48];
                got.mid = m_tdata[175:112];
                got.hi = m_tdata[207:176];
                got.last = m_tlast;
                tracker.result_seen(got);
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Ends the run when no item moves on either side for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** selective_repeat_receiver_core: FAILED **");
        $finish;
    end

    initial
    begin : main_flow
        tracker = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset window of 8, base at 1
        directed_items.insert(directed_items.size(),
                              make_packet(16'd1, 16'hFFFF, '1, '1, '1, 1'b0));
        directed_items.insert(directed_items.size(),
                              make_packet(16'd3, 16'h0000, '0, '0, '0, 1'b0));
        // duplicate overwrites the stored slot, most negative bytes
        directed_items.insert(directed_items.size(),
                              make_packet(16'd3, 16'h1234, {8{8'h80}}, {8{8'h80}},
                                          {4{8'h80}}, 1'b0));
        // last slot inside the window, then the first one past it
        directed_items.insert(directed_items.size(),
                              make_packet(16'd9, 16'h00FF, {8{8'h7F}}, {8{8'h7F}},
                                          {4{8'h7F}}, 1'b0));
        directed_items.insert(directed_items.size(),
                              make_packet(16'd10, 16'hA5A5, rand64(), rand64(), $urandom,
                                          1'b0));
        directed_items.insert(directed_items.size(),
                              make_packet(16'd2, 16'h8000, rand64(), rand64(), $urandom,
                                          1'b0));
        // old packets, distance taken across the sequence wrap
        directed_items.insert(directed_items.size(),
                              make_packet(16'd0, 16'h0001, rand64(), rand64(), $urandom,
                                          1'b0));
        directed_items.insert(directed_items.size(),
                              make_packet(16'hFFFF, 16'h7FFF, rand64(), rand64(), $urandom,
                                          1'b0));
        directed_items.insert(directed_items.size(),
                              make_packet(16'd4, 16'h0042, rand64(), rand64(), $urandom,
                                          1'b1));
        directed_items.insert(directed_items.size(),
                              make_packet(16'd4, 16'h0042, rand64(), rand64(), $urandom,
                                          1'b0));
        for (int s = 8; s >= 5; s--)
        begin
            directed_items.insert(directed_items.size(),
                                  make_packet(16'(s), 16'($urandom), rand64(), rand64(),
                                              $urandom, 1'b0));
        end
        directed_items.insert(directed_items.size(),
                              make_packet(16'd3, 16'h5A5A, rand64(), rand64(), $urandom,
                                          1'b0));
        directed_items.insert(directed_items.size(),
                              make_packet(16'($urandom), 16'($urandom), rand64(), rand64(),
                                          $urandom, 1'b1));
        directed_items.insert(directed_items.size(),
                              make_packet(16'd17, 16'($urandom), rand64(), rand64(),
                                          $urandom, 1'b0));
        directed_items.insert(directed_items.size(),
                              make_packet(16'd18, 16'($urandom), rand64(), rand64(),
                                          $urandom, 1'b0));
        send_packets(directed_items.size());

        // Random phases: new window setting and traffic pattern each
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_for_drain();
            write_window(5'(PHASE_WIN[ph]));
            send_idle_pct = PHASE_SEND_IDLE[ph];
            recv_stall_pct = PHASE_RECV_STALL[ph];
            hold_request = PHASE_HOLD[ph];
            send_packets(PHASE_ITEMS[ph]);
        end

        while (tracker.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.owed.size() != 0)
        begin
            $error("%0d result items never arrived", tracker.owed.size());
            tracker.failures++;
        end
        if (tracker.failures == 0)
            $display("** selective_repeat_receiver_core: PASSED **");
        else
            $display("** selective_repeat_receiver_core: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/srr_pkg.sv
rtl/srr_ram.sv
rtl/srr_sum_unit.sv
rtl/selective_repeat_receiver_core.sv
sim/tb_selective_repeat_receiver_core.sv
